@@ sv/lpfd_pkg.sv @@
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned HDR_SHIFT_W = 24;
  localparam int unsigned HDR_CNT_W   = 2;

  localparam logic [LEN_W-1:0]     MAX_LEN_RESET = 32'd65536;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST_IDX  = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_of_message;
    logic [LEN_W-1:0]  message_count;
  } lpfd_result_t;

endpackage

`default_nettype wire

@@ sv/lpfd_parser.sv @@
// ----------------------------------------------------------------------------
// lpfd_parser
// Header collection, skip and payload counters; one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_parser (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic [lpfd_pkg::BYTE_W-1:0] data_byte,
  input  wire logic [lpfd_pkg::LEN_W-1:0]  max_frame_length,
  output lpfd_pkg::lpfd_result_t          result
);
  import lpfd_pkg::*;

  logic [HDR_SHIFT_W-1:0] header_shift, header_shift_next;
  logic [HDR_CNT_W-1:0]   header_count, header_count_next;
  logic                   in_payload, in_payload_next;
  logic [LEN_W-1:0]       payload_remaining, payload_remaining_next;
  logic [LEN_W-1:0]       skip_remaining, skip_remaining_next;
  logic [LEN_W-1:0]       completed_messages, completed_messages_next;
  logic [LEN_W-1:0]       frame_len;
  logic [LEN_W-1:0]       remaining_dec;

  assign frame_len = {data_byte, header_shift};

  always_comb begin
    header_shift_next       = header_shift;
    header_count_next       = header_count;
    in_payload_next         = in_payload;
    payload_remaining_next  = payload_remaining;
    skip_remaining_next     = skip_remaining;
    completed_messages_next = completed_messages;
    remaining_dec           = payload_remaining;
    result.valid            = 1'b0;
    result.payload_byte     = data_byte;
    result.last_of_message  = 1'b0;
    result.message_count    = completed_messages;

    if (skip_remaining != '0) begin
      skip_remaining_next = skip_remaining - LEN_W'(1);
    end else if (!in_payload) begin
      if (header_count != HDR_LAST_IDX) begin
        unique case (header_count)
          2'd0:    header_shift_next = {header_shift[23:8], data_byte};
          2'd1:    header_shift_next = {header_shift[23:16], data_byte, header_shift[7:0]};
          default: header_shift_next = {data_byte, header_shift[15:0]};
        endcase
        header_count_next = header_count + HDR_CNT_W'(1);
      end else begin
        header_shift_next = '0;
        header_count_next = '0;
        if (frame_len == '0) begin
          in_payload_next = 1'b0;
        end else if (frame_len > max_frame_length) begin
          skip_remaining_next = frame_len;
        end else begin
          in_payload_next        = 1'b1;
          payload_remaining_next = frame_len;
        end
      end
    end else begin
      if (payload_remaining != '0) begin
        remaining_dec = payload_remaining - LEN_W'(1);
      end
      payload_remaining_next = remaining_dec;
      result.valid           = 1'b1;
      if (remaining_dec == '0) begin
        in_payload_next         = 1'b0;
        completed_messages_next = completed_messages + LEN_W'(1);
        result.last_of_message  = 1'b1;
        result.message_count    = completed_messages_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_shift       <= '0;
      header_count       <= '0;
      in_payload         <= 1'b0;
      payload_remaining  <= '0;
      skip_remaining     <= '0;
      completed_messages <= '0;
    end else if (step) begin
      header_shift       <= header_shift_next;
      header_count       <= header_count_next;
      in_payload         <= in_payload_next;
      payload_remaining  <= payload_remaining_next;
      skip_remaining     <= skip_remaining_next;
      completed_messages <= completed_messages_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/length_prefixed_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Splits a byte stream of length-prefixed frames into payload bytes.
// ----------------------------------------------------------------------------
// Each frame is a 4-byte little-endian length followed by that many payload
// bytes. Zero-length frames vanish; frames longer than max_frame_length are
// skipped byte by byte. Accepted payload bytes come out one per transaction,
// m_tlast on the final byte, with the wrapping count of completed frames.
// One byte is taken per cycle while m_tready is high: an input register
// and an output register frame a single stage of counter logic.
// max_frame_length resets to 65536 and takes effect at the next completed
// header.
`default_nettype none

module length_prefixed_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // chunk_end
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata,   // [7:0] payload_byte, [39:8] message_count
  output      logic        m_tlast    // last_of_message
);
  import lpfd_pkg::*;

  logic [LEN_W-1:0]  max_frame_length;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_chunk_end;
  logic              advance;
  lpfd_result_t      result;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_frame_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte      <= s_tdata;
      in_chunk_end <= s_tlast;
    end
  end

  lpfd_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .data_byte        (in_byte),
    .max_frame_length (max_frame_length),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= result.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      m_tdata <= {result.message_count, result.payload_byte};
      m_tlast <= result.last_of_message || (in_chunk_end && 1'b0);
    end
  end

endmodule

`default_nettype wire

@@ verif/length_prefixed_frame_deframer_test.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_test
// Self-checking testbench for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
// A short stimulus table covers the reset state, the data extremes, empty and
// oversized frames and both extremes of max_frame_length. Random frame
// streams follow, split into phases with a new max_frame_length written
// between them, often while a frame is still half parsed. A byte-level copy
// of the parser predicts the payloads that the table does not give. Random
// input gaps and output stalls run unless a phase holds that side steady.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpfd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_NONE,
    ROW_RESULT,
    ROW_PREDICT
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] value;
    logic        chunk_end;
    logic        exp_last;
    logic [31:0] exp_count;
  } stim_row_t;

  localparam int unsigned N_ROWS = 23;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    '{ROW_NONE,    32'h02,        1'b0, 1'b0, 32'd0},
    '{ROW_NONE,    32'h00,        1'b0, 1'b0, 32'd0},
    '{ROW_NONE,    32'h00,        1'b0, 1'b0, 32'd0},
    '{ROW_NONE,    32'h00,        1'b0, 1'b0, 32'd0},
    '{ROW_RESULT,  32'hFF,        1'b0, 1'b0, 32'd0},
    '{ROW_RESULT,  32'h00,        1'b1, 1'b1, 32'd1},
    '{ROW_NONE,    32'h00,        1'b0, 1'b0, 32'd0},
    '{ROW_NONE,    32'h00,        1'b0, 1'b0, 32'd0},
    '{ROW_NONE,    32'h00,        1'b0, 1'b0, 32'd0},
    '{ROW_NONE,    32'h00,        1'b1, 1'b0, 32'd0},
    '{ROW_CFG,     32'h0,         1'b0, 1'b0, 32'd0},
    '{ROW_NONE,    32'h02,        1'b0, 1'b0, 32'd0},
    '{ROW_NONE,    32'h00,        1'b0, 1'b0, 32'd0},
    '{ROW_NONE,    32'h00,        1'b0, 1'b0, 32'd0},
    '{ROW_NONE,    32'h00,        1'b0, 1'b0, 32'd0},
    '{ROW_NONE,    32'hAB,        1'b0, 1'b0, 32'd0},
    '{ROW_NONE,    32'h54,        1'b1, 1'b0, 32'd0},
    '{ROW_CFG,     32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICT, 32'h01,        1'b0, 1'b0, 32'd0},
    '{ROW_PREDICT, 32'h00,        1'b0, 1'b0, 32'd0},
    '{ROW_PREDICT, 32'h00,        1'b0, 1'b0, 32'd0},
    '{ROW_PREDICT, 32'h00,        1'b0, 1'b0, 32'd0},
    '{ROW_PREDICT, 32'h7E,        1'b1, 1'b0, 32'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // [7:0] data_byte
  logic        s_tlast = 1'b0;   // chunk_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;          // [7:0] payload_byte, [39:8] message_count
  logic        m_tlast;          // last_of_message

  length_prefixed_frame_deframer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #2 clk = ~clk;

  // parser copy
  logic [LEN_W-1:0]       mdl_max_len = MAX_LEN_RESET;
  logic [HDR_SHIFT_W-1:0] hdr_acc     = '0;
  logic [HDR_CNT_W-1:0]   hdr_cnt     = '0;
  bit                     in_body     = 1'b0;
  logic [LEN_W-1:0]       body_left   = '0;
  logic [LEN_W-1:0]       skip_left   = '0;
  logic [LEN_W-1:0]       done_frames = '0;

  lpfd_result_t   expected_bytes[$];
  logic [7:0]     stream_q[$];
  lpfd_result_t   want;
  int unsigned    mismatches = 0;
  int unsigned    bytes_checked = 0;
  int unsigned    bytes_in = 0;
  int unsigned    settings_used = 0;
  int unsigned    cycle_count = 0;
  int unsigned    stall_left = 0;
  bit             src_steady = 1'b0;
  bit             sink_steady = 1'b0;

  function automatic bit deframe_byte(input logic [7:0] b, output lpfd_result_t r);
    logic [LEN_W-1:0] len;
    r = '0;
    if (skip_left != 0) begin
      skip_left = skip_left - 1;
      return 1'b0;
    end
    if (!in_body) begin
      if (hdr_cnt < HDR_LAST_IDX) begin
        hdr_acc[8*hdr_cnt +: 8] = b;
        hdr_cnt = hdr_cnt + HDR_CNT_W'(1);
        return 1'b0;
      end
      len = {b, hdr_acc};
      hdr_acc = '0;
      hdr_cnt = '0;
      if (len == 0) return 1'b0;
      if (len > mdl_max_len) begin
        skip_left = len;
        return 1'b0;
      end
      in_body = 1'b1;
      body_left = len;
      return 1'b0;
    end
    if (body_left != 0) body_left = body_left - 1;
    if (body_left == 0) begin
      r.last_of_message = 1'b1;
      in_body = 1'b0;
      done_frames = done_frames + 1;
    end
    r.valid = 1'b1;
    r.payload_byte = b;
    r.message_count = done_frames;
    return 1'b1;
  endfunction

  function automatic logic [7:0] next_stream_byte();
    logic [31:0] len;
    int unsigned pick;
    if (stream_q.size() == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) len = 0;
      else if (pick < 25 && mdl_max_len < 40) len = mdl_max_len + 1;
      else if (pick < 28 && mdl_max_len < 256) len = $urandom_range(256, 300);
      else if (pick < 40 && mdl_max_len >= 1 && mdl_max_len <= 40) len = mdl_max_len;
      else len = $urandom_range(1, 12);
      for (int i = 0; i < 4; i++) stream_q.push_back(len[8*i +: 8]);
      repeat (len) stream_q.push_back(8'($urandom));
    end
    return stream_q.pop_front();
  endfunction

  function automatic int unsigned source_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (src_steady || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic feed_byte(input logic [7:0] b, input logic ce, input row_kind_e kind,
                           input lpfd_result_t typed);
    lpfd_result_t pred;
    bit produced;
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= ce;
    do @(posedge clk); while (!s_tready);
    bytes_in++;
    produced = deframe_byte(b, pred);
    if (kind == ROW_RESULT) expected_bytes.push_back(typed);
    else if (kind == ROW_PREDICT && produced) expected_bytes.push_back(pred);
    gap = source_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_max_len(input logic [31:0] v);
    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_max_len = v;
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!sink_steady && $urandom_range(0, 99) < 25) begin
      m_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: byte %02h last %0b count %0d",
                   m_tdata[7:0], m_tlast, m_tdata[39:8]);
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata[7:0] !== want.payload_byte || m_tlast !== want.last_of_message ||
            m_tdata[39:8] !== want.message_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("payload %0d: expected byte %02h last %0b count %0d, got byte %02h last %0b count %0d",
                     bytes_checked, want.payload_byte, want.last_of_message,
                     want.message_count, m_tdata[7:0], m_tlast, m_tdata[39:8]);
        end
        bytes_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transactions outstanding",
               cycle_count, expected_bytes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned random_items;
    int unsigned phase;
    int unsigned n;
    logic [31:0] v;
    random_items = 0;
    phase = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        write_max_len(DIRECTED[i].value);
      end else begin
        feed_byte(DIRECTED[i].value[7:0], DIRECTED[i].chunk_end, DIRECTED[i].kind,
                  '{1'b1, DIRECTED[i].value[7:0], DIRECTED[i].exp_last,
                    DIRECTED[i].exp_count});
      end
    end

    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: v = '0;
        1: v = 32'hFFFF_FFFF;
        default: begin
          case ($urandom_range(0, 5))
            0: v = '0;
            1: v = 32'hFFFF_FFFF;
            2: v = $urandom_range(1, 12);
            3: v = $urandom_range(13, 40);
            4: v = MAX_LEN_RESET;
            default: v = $urandom;
          endcase
        end
      endcase
      write_max_len(v);
      src_steady <= ($urandom_range(0, 3) == 0);
      sink_steady <= ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 70);
      repeat (n) begin
        random_items++;
        feed_byte(next_stream_byte(), $urandom_range(0, 5) == 0, ROW_PREDICT, '0);
      end
      phase++;
    end

    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d stream bytes in over %0d max_frame_length settings",
             bytes_in, settings_used);
    $display("%0d payload bytes checked, %0d frames completed, %0d mismatches",
             bytes_checked, done_frames, mismatches);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
